@@ rtl/core/lchd_pkg.sv @@
package lchd_pkg;

  localparam int unsigned CodeW   = 10;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned StampW  = 32;
  localparam int unsigned ShotW   = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CodeW-1:0]  UpCodeRst    = CodeW'(276);
  localparam logic [CodeW-1:0]  DownCodeRst  = CodeW'(275);
  localparam logic [TicksW-1:0] HoldTicksRst = TicksW'(20);
  localparam logic [TicksW-1:0] ChordTicksRst = TicksW'(30);

  typedef enum logic [CfgIdxW-1:0] {
    REG_UP_CODE     = 2'd0,
    REG_DOWN_CODE   = 2'd1,
    REG_HOLD_TICKS  = 2'd2,
    REG_CHORD_TICKS = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic [CodeW-1:0]  up_key_code;
    logic [CodeW-1:0]  down_key_code;
    logic [TicksW-1:0] hold_ticks;
    logic [TicksW-1:0] chord_ticks;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic [CodeW-1:0] key_code;
    logic             is_press;
  } item_t;

  typedef struct packed {
    logic             volume_up_pulse;
    logic             volume_down_pulse;
    logic             copy_fire;
    logic             paste_fire;
    logic             screenshot_fire;
    logic [ShotW-1:0] screenshot_number;
  } result_t;

endpackage

@@ rtl/core/two_button_hold_and_chord_detector.sv @@
// Detects presses, long single-button holds and a two-button chord from a
// stream of key events and time ticks.
// Input channel (in_valid/in_ready): one transaction is either a key event
// (in_op = 0, with in_key_code and in_is_press) or one tick (in_op = 1).
// Output channel (out_valid/out_ready): exactly one result transaction per
// input transaction, in order, carrying the press pulses, the copy, paste
// and screenshot fire flags and the screenshot number.
// An accepted transaction waits in the input register; when the result
// register is free or drains, it is evaluated against the detector state
// and lands in the result register, raising out_valid. Throughput is one
// transaction per cycle without receiver stalls; the state update path (three
// 32-bit elapsed-time subtract and compares) is the single stage of work.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction before in_ready drops.
// Each cfg_ write sets one key code or tick threshold, chosen by cfg_index;
// use it only while no transaction is in flight; the block does not enforce it.
// Synchronous reset restores the default codes and thresholds, clears the
// tick count, held flags, chord state and screenshot counter, and empties
// both registers.
module two_button_hold_and_chord_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [lchd_pkg::CodeW-1:0]    in_key_code,
  input  logic                          in_is_press,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_volume_up_pulse,
  output logic                          out_volume_down_pulse,
  output logic                          out_copy_fire,
  output logic                          out_paste_fire,
  output logic                          out_screenshot_fire,
  output logic [lchd_pkg::ShotW-1:0]    out_screenshot_number,
  input  logic                          cfg_we,
  input  logic [lchd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lchd_pkg::CfgDataW-1:0] cfg_data
);
  import lchd_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  result_t res;
  result_t res_r;
  logic    in_valid_r, in_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;

  // The held item moves on whenever the result register is empty or drains.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign in_valid_nxt  = (in_valid && in_ready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  lchd_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  lchd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op       <= in_op;
      item_r.key_code <= in_key_code;
      item_r.is_press <= in_is_press;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_volume_up_pulse   = res_r.volume_up_pulse;
  assign out_volume_down_pulse = res_r.volume_down_pulse;
  assign out_copy_fire         = res_r.copy_fire;
  assign out_paste_fire        = res_r.paste_fire;
  assign out_screenshot_fire   = res_r.screenshot_fire;
  assign out_screenshot_number = res_r.screenshot_number;

endmodule

@@ rtl/core/lchd_cfg.sv @@
module lchd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [lchd_pkg::CfgIdxW-1:0]   index,
  input  logic [lchd_pkg::CfgDataW-1:0]  data,
  output lchd_pkg::cfg_t                 cfg
);
  import lchd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (cfg_reg_t'(index))
        REG_UP_CODE:     cfg_nxt.up_key_code   = data[CodeW-1:0];
        REG_DOWN_CODE:   cfg_nxt.down_key_code = data[CodeW-1:0];
        REG_HOLD_TICKS:  cfg_nxt.hold_ticks    = data[TicksW-1:0];
        REG_CHORD_TICKS: cfg_nxt.chord_ticks   = data[TicksW-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_key_code   <= UpCodeRst;
      cfg_r.down_key_code <= DownCodeRst;
      cfg_r.hold_ticks    <= HoldTicksRst;
      cfg_r.chord_ticks   <= ChordTicksRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/lchd_core.sv @@
module lchd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lchd_pkg::item_t   item,
  input  lchd_pkg::cfg_t    cfg,
  output lchd_pkg::result_t res
);
  import lchd_pkg::*;

  logic [StampW-1:0] tick_now_r, tick_now_nxt;
  logic [StampW-1:0] up_stamp_r, up_stamp_nxt;
  logic [StampW-1:0] down_stamp_r, down_stamp_nxt;
  logic [StampW-1:0] chord_stamp_r, chord_stamp_nxt;
  logic [ShotW-1:0]  shot_count_r, shot_count_nxt;
  logic up_held_r, up_held_nxt;
  logic down_held_r, down_held_nxt;
  logic chord_active_r, chord_active_nxt;
  logic copy_done_r, copy_done_nxt;
  logic paste_done_r, paste_done_nxt;
  logic shot_done_r, shot_done_nxt;

  logic              up_match, down_match;
  logic [StampW-1:0] tick_inc;
  logic [StampW-1:0] up_elapsed, down_elapsed, chord_elapsed;
  logic              copy_hit, paste_hit, shot_hit;
  logic              up_key, down_key;

  // The up button wins when both codes are programmed to the same value.
  assign up_match   = (item.key_code == cfg.up_key_code);
  assign down_match = !up_match && (item.key_code == cfg.down_key_code);

  assign tick_inc      = tick_now_r + StampW'(1);
  assign up_elapsed    = tick_inc - up_stamp_r;
  assign down_elapsed  = tick_inc - down_stamp_r;
  assign chord_elapsed = tick_inc - chord_stamp_r;

  assign copy_hit = up_held_r && !copy_done_r && !chord_active_r &&
                    (up_elapsed >= StampW'(cfg.hold_ticks));
  assign paste_hit = down_held_r && !paste_done_r && !chord_active_r &&
                     (down_elapsed >= StampW'(cfg.hold_ticks));
  assign shot_hit = chord_active_r && up_held_r && down_held_r && !shot_done_r &&
                    (chord_elapsed >= StampW'(cfg.chord_ticks));

  always_comb begin
    tick_now_nxt     = tick_now_r;
    up_stamp_nxt     = up_stamp_r;
    down_stamp_nxt   = down_stamp_r;
    chord_stamp_nxt  = chord_stamp_r;
    shot_count_nxt   = shot_count_r;
    up_held_nxt      = up_held_r;
    down_held_nxt    = down_held_r;
    chord_active_nxt = chord_active_r;
    copy_done_nxt    = copy_done_r;
    paste_done_nxt   = paste_done_r;
    shot_done_nxt    = shot_done_r;
    up_key           = 1'b0;
    down_key         = 1'b0;
    res              = '0;

    if (op_t'(item.op) == OP_KEY) begin
      if (up_match) begin
        up_held_nxt = item.is_press;
        if (item.is_press) begin
          up_stamp_nxt  = tick_now_r;
          copy_done_nxt = 1'b0;
          up_key        = 1'b1;
        end
      end else if (down_match) begin
        down_held_nxt = item.is_press;
        if (item.is_press) begin
          down_stamp_nxt = tick_now_r;
          paste_done_nxt = 1'b0;
          down_key       = 1'b1;
        end
      end
      // The chord follows the held flags after this transaction.
      if (up_held_nxt && down_held_nxt && !chord_active_r) begin
        chord_active_nxt = 1'b1;
        shot_done_nxt    = 1'b0;
        chord_stamp_nxt  = tick_now_r;
      end else if (!up_held_nxt || !down_held_nxt) begin
        chord_active_nxt = 1'b0;
        shot_done_nxt    = 1'b0;
      end
      res.volume_up_pulse   = up_key;
      res.volume_down_pulse = down_key;
    end else begin
      tick_now_nxt = tick_inc;
      if (copy_hit) begin
        copy_done_nxt = 1'b1;
      end
      if (paste_hit) begin
        paste_done_nxt = 1'b1;
      end
      if (shot_hit) begin
        shot_count_nxt   = shot_count_r + ShotW'(1);
        shot_done_nxt    = 1'b1;
        chord_active_nxt = 1'b0;
        up_held_nxt      = 1'b0;
        down_held_nxt    = 1'b0;
        res.screenshot_number = shot_count_r;
      end
      res.copy_fire       = copy_hit;
      res.paste_fire      = paste_hit;
      res.screenshot_fire = shot_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_now_r     <= '0;
      up_stamp_r     <= '0;
      down_stamp_r   <= '0;
      chord_stamp_r  <= '0;
      shot_count_r   <= '0;
      up_held_r      <= 1'b0;
      down_held_r    <= 1'b0;
      chord_active_r <= 1'b0;
      copy_done_r    <= 1'b0;
      paste_done_r   <= 1'b0;
      shot_done_r    <= 1'b0;
    end else if (en) begin
      tick_now_r     <= tick_now_nxt;
      up_stamp_r     <= up_stamp_nxt;
      down_stamp_r   <= down_stamp_nxt;
      chord_stamp_r  <= chord_stamp_nxt;
      shot_count_r   <= shot_count_nxt;
      up_held_r      <= up_held_nxt;
      down_held_r    <= down_held_nxt;
      chord_active_r <= chord_active_nxt;
      copy_done_r    <= copy_done_nxt;
      paste_done_r   <= paste_done_nxt;
      shot_done_r    <= shot_done_nxt;
    end
  end

endmodule

@@ test/two_button_hold_and_chord_detector_test.sv @@
module two_button_hold_and_chord_detector_test;
  import lchd_pkg::*;

  localparam logic [CodeW-1:0] CodeMin   = '0;
  localparam logic [CodeW-1:0] CodeMax   = '1;
  localparam logic [CodeW-1:0] CodeOther = CodeW'(5);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = 1'b0;
  logic [CodeW-1:0]    in_key_code = '0;
  logic                in_is_press = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_volume_up_pulse;
  logic                out_volume_down_pulse;
  logic                out_copy_fire;
  logic                out_paste_fire;
  logic                out_screenshot_fire;
  logic [ShotW-1:0]    out_screenshot_number;
  logic                cfg_we = 1'b0;
  cfg_reg_t            cfg_index = REG_UP_CODE;
  logic [CfgDataW-1:0] cfg_data = '0;

  two_button_hold_and_chord_detector dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_key_code           (in_key_code),
    .in_is_press           (in_is_press),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_volume_up_pulse   (out_volume_up_pulse),
    .out_volume_down_pulse (out_volume_down_pulse),
    .out_copy_fire         (out_copy_fire),
    .out_paste_fire        (out_paste_fire),
    .out_screenshot_fire   (out_screenshot_fire),
    .out_screenshot_number (out_screenshot_number),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // Register copies kept by the gesture predictor.
  logic [CodeW-1:0]  up_code = UpCodeRst;
  logic [CodeW-1:0]  down_code = DownCodeRst;
  logic [TicksW-1:0] hold_limit = HoldTicksRst;
  logic [TicksW-1:0] chord_limit = ChordTicksRst;

  // Detector state as the predictor sees it.
  logic [StampW-1:0] tick_count = '0;
  logic [StampW-1:0] up_since = '0;
  logic [StampW-1:0] down_since = '0;
  logic [StampW-1:0] chord_start = '0;
  logic              up_is_held = 1'b0;
  logic              down_is_held = 1'b0;
  logic              chord_on = 1'b0;
  logic              copy_sent = 1'b0;
  logic              paste_sent = 1'b0;
  logic              shot_sent = 1'b0;
  logic [ShotW-1:0]  next_shot = '0;

  item_t   key_stream[$];
  result_t gestures_due[$];
  item_t   taken;
  result_t want;

  int mismatches = 0;
  int results_seen = 0;
  int items_taken = 0;
  int settings_used = 1;
  int copies_seen = 0;
  int pastes_seen = 0;
  int shots_seen = 0;
  int idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;
  int drain_cycles;

  function automatic result_t predict_gestures(input item_t it);
    result_t           r;
    logic [StampW-1:0] up_for;
    logic [StampW-1:0] down_for;
    logic [StampW-1:0] chord_for;
    r = '0;
    if (it.op == OP_KEY) begin
      // Equal codes resolve to the up button.
      if (it.key_code == up_code) begin
        up_is_held = it.is_press;
        if (it.is_press) begin
          up_since = tick_count;
          copy_sent = 1'b0;
          r.volume_up_pulse = 1'b1;
        end
      end else if (it.key_code == down_code) begin
        down_is_held = it.is_press;
        if (it.is_press) begin
          down_since = tick_count;
          paste_sent = 1'b0;
          r.volume_down_pulse = 1'b1;
        end
      end
      if (up_is_held && down_is_held && !chord_on) begin
        chord_on = 1'b1;
        shot_sent = 1'b0;
        chord_start = tick_count;
      end else if (!up_is_held || !down_is_held) begin
        chord_on = 1'b0;
        shot_sent = 1'b0;
      end
    end else begin
      tick_count = tick_count + StampW'(1);
      up_for = tick_count - up_since;
      down_for = tick_count - down_since;
      chord_for = tick_count - chord_start;
      if (up_is_held && !copy_sent && !chord_on && up_for >= StampW'(hold_limit)) begin
        r.copy_fire = 1'b1;
        copy_sent = 1'b1;
        copies_seen++;
      end
      if (down_is_held && !paste_sent && !chord_on && down_for >= StampW'(hold_limit)) begin
        r.paste_fire = 1'b1;
        paste_sent = 1'b1;
        pastes_seen++;
      end
      if (chord_on && up_is_held && down_is_held && !shot_sent &&
          chord_for >= StampW'(chord_limit)) begin
        r.screenshot_fire = 1'b1;
        r.screenshot_number = next_shot;
        next_shot = next_shot + ShotW'(1);
        shot_sent = 1'b1;
        chord_on = 1'b0;
        up_is_held = 1'b0;
        down_is_held = 1'b0;
        shots_seen++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got,
             exp_val);
    mismatches++;
  endtask

  task automatic queue_key(input logic [CodeW-1:0] code, input logic press);
    item_t it;
    it.op = OP_KEY;
    it.key_code = code;
    it.is_press = press;
    key_stream.push_back(it);
  endtask

  task automatic queue_ticks(input int n);
    item_t it;
    repeat (n) begin
      it.op = OP_TICK;
      it.key_code = CodeW'($urandom_range(0, 1023));
      it.is_press = 1'($urandom_range(0, 1));
      key_stream.push_back(it);
    end
  endtask

  // Mostly well-formed holds and chords with random lengths, plus broken
  // sequences and unrelated noise.
  task automatic queue_random_gestures(input int count);
    int               goal;
    int               roll;
    int               hold_span;
    int               chord_span;
    logic [CodeW-1:0] first;
    logic [CodeW-1:0] second;
    item_t            it;
    goal = key_stream.size() + count;
    hold_span = (int'(hold_limit) < 10) ? int'(hold_limit) + 2 : 10;
    chord_span = (int'(chord_limit) < 10) ? int'(chord_limit) + 2 : 10;
    while (key_stream.size() < goal) begin
      roll = $urandom_range(0, 9);
      first = $urandom_range(0, 1) ? up_code : down_code;
      second = (first == up_code) ? down_code : up_code;
      if (roll < 4) begin
        queue_key(first, 1'b1);
        queue_ticks($urandom_range(0, hold_span));
        if ($urandom_range(0, 1)) queue_key(first, 1'b0);
      end else if (roll < 7) begin
        queue_key(first, 1'b1);
        queue_ticks($urandom_range(0, 2));
        queue_key(second, 1'b1);
        queue_ticks($urandom_range(0, chord_span));
        if ($urandom_range(0, 1)) queue_key($urandom_range(0, 1) ? first : second, 1'b0);
      end else if (roll < 8) begin
        queue_key(first, 1'($urandom_range(0, 1)));
        queue_key(first, 1'b0);
        queue_ticks($urandom_range(0, 2));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          it.op = 1'($urandom_range(0, 1));
          it.key_code = CodeW'($urandom_range(0, 1023));
          it.is_press = 1'($urandom_range(0, 1));
          key_stream.push_back(it);
        end
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataW'(value);
    case (idx)
      REG_UP_CODE:     up_code = CodeW'(value);
      REG_DOWN_CODE:   down_code = CodeW'(value);
      REG_HOLD_TICKS:  hold_limit = TicksW'(value);
      REG_CHORD_TICKS: chord_limit = TicksW'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_codes();
    int a;
    int b;
    a = $urandom_range(0, 1023);
    b = $urandom_range(0, 1023);
    while (b == a) b = $urandom_range(0, 1023);
    write_reg(REG_UP_CODE, a);
    write_reg(REG_DOWN_CODE, b);
  endtask

  // Waits until every transaction has been sent and answered, then lets the
  // pipeline settle before the registers are touched.
  task automatic settle();
    @(negedge clk);
    while (key_stream.size() != 0 || in_valid || gestures_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    settings_used++;
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.op = in_op;
        taken.key_code = in_key_code;
        taken.is_press = in_is_press;
        gestures_due.push_back(predict_gestures(taken));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          in_gap = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else if (key_stream.size() != 0) begin
          taken = key_stream.pop_front();
          in_valid <= 1'b1;
          in_op <= taken.op;
          in_key_code <= taken.key_code;
          in_is_press <= taken.is_press;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (gestures_due.size() == 0) begin
          report_mismatch("transaction with nothing pending", 1, 0);
        end else begin
          want = gestures_due.pop_front();
          if (out_volume_up_pulse !== want.volume_up_pulse)
            report_mismatch("volume_up_pulse", int'(out_volume_up_pulse),
                            int'(want.volume_up_pulse));
          if (out_volume_down_pulse !== want.volume_down_pulse)
            report_mismatch("volume_down_pulse", int'(out_volume_down_pulse),
                            int'(want.volume_down_pulse));
          if (out_copy_fire !== want.copy_fire)
            report_mismatch("copy_fire", int'(out_copy_fire), int'(want.copy_fire));
          if (out_paste_fire !== want.paste_fire)
            report_mismatch("paste_fire", int'(out_paste_fire), int'(want.paste_fire));
          if (out_screenshot_fire !== want.screenshot_fire)
            report_mismatch("screenshot_fire", int'(out_screenshot_fire),
                            int'(want.screenshot_fire));
          if (out_screenshot_number !== want.screenshot_number)
            report_mismatch("screenshot_number", int'(out_screenshot_number),
                            int'(want.screenshot_number));
        end
        results_seen++;
      end
      // One long stall while the sender keeps offering, so the block backs up.
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 80 && !long_hold_done) begin
        long_hold_done = 1'b1;
        long_hold_left = 59;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_gap = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short thresholds and the extreme key codes for the directed part.
    idle_pct = 15;
    write_reg(REG_UP_CODE, 0);
    write_reg(REG_DOWN_CODE, 1023);
    write_reg(REG_HOLD_TICKS, 2);
    write_reg(REG_CHORD_TICKS, 3);
    queue_key(CodeMax, 1'b1);
    queue_ticks(3);
    queue_key(CodeMin, 1'b1);
    queue_ticks(4);
    queue_key(CodeMin, 1'b1);
    queue_key(CodeMin, 1'b0);
    queue_key(CodeMin, 1'b0);
    queue_key(CodeOther, 1'b1);
    queue_key(CodeMin, 1'b1);
    queue_ticks(2);
    queue_key(CodeMax, 1'b1);
    queue_key(CodeMax, 1'b0);
    queue_ticks(1);
    queue_key(CodeMax, 1'b1);
    queue_ticks(3);
    queue_key(CodeMax, 1'b0);
    settle();

    // Both buttons share one code: only the up button may react.
    write_reg(REG_DOWN_CODE, 0);
    queue_key(CodeMin, 1'b1);
    queue_key(CodeMin, 1'b0);
    queue_key(CodeMin, 1'b1);
    queue_ticks(3);
    queue_key(CodeMin, 1'b0);
    settle();

    // Zero thresholds are met on the first tick.
    write_reg(REG_DOWN_CODE, 1023);
    write_reg(REG_HOLD_TICKS, 0);
    write_reg(REG_CHORD_TICKS, 0);
    queue_key(CodeMax, 1'b1);
    queue_ticks(1);
    queue_key(CodeMin, 1'b1);
    queue_ticks(2);
    settle();

    idle_pct = 20;
    random_codes();
    write_reg(REG_HOLD_TICKS, $urandom_range(1, 6));
    write_reg(REG_CHORD_TICKS, $urandom_range(1, 6));
    queue_random_gestures(120);
    settle();

    idle_pct = 10;
    write_reg(REG_HOLD_TICKS, 1);
    write_reg(REG_CHORD_TICKS, 1);
    queue_random_gestures(80);
    settle();

    idle_pct = 0;
    write_reg(REG_UP_CODE, 1023);
    write_reg(REG_DOWN_CODE, 0);
    write_reg(REG_HOLD_TICKS, 65535);
    write_reg(REG_CHORD_TICKS, 65535);
    queue_random_gestures(80);
    settle();

    // A run of back-to-back chords, each one firing on its first tick.
    idle_pct = 5;
    write_reg(REG_HOLD_TICKS, 3);
    write_reg(REG_CHORD_TICKS, 1);
    repeat (40) begin
      if ($urandom_range(0, 1)) begin
        queue_key(CodeMax, 1'b1);
        queue_key(CodeMin, 1'b1);
      end else begin
        queue_key(CodeMin, 1'b1);
        queue_key(CodeMax, 1'b1);
      end
      queue_ticks(1);
    end
    settle();

    idle_pct = 0;
    random_codes();
    write_reg(REG_HOLD_TICKS, $urandom_range(2, 5));
    write_reg(REG_CHORD_TICKS, $urandom_range(2, 5));
    queue_random_gestures(60);

    drain_cycles = 0;
    while ((key_stream.size() != 0 || in_valid || gestures_due.size() != 0) &&
           drain_cycles < 200000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (10) @(negedge clk);
    if (gestures_due.size() != 0)
      report_mismatch("results never delivered", gestures_due.size(), 0);

    $display("Ran %0d transactions and checked %0d results under %0d register settings.",
             items_taken, results_seen, settings_used);
    $display("Expected %0d copies, %0d pastes and %0d screenshots; %0d mismatches.",
             copies_seen, pastes_seen, shots_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("Timed out waiting for the detector.");
    $display("Regression FAIL");
    $finish;
  end

endmodule
